// ===== rtl/slps_pkg.sv =====
// Shared types, constants and helpers of the status LED pattern sequencer.
package slps_pkg;

    localparam int TimeW    = 32;
    localparam int PeriodW  = 16;
    localparam int LevelW   = 8;
    localparam int ActionW  = 2;
    localparam int PatternW = 3;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    typedef logic [ActionW-1:0]  action_t;
    typedef logic [TimeW-1:0]    time_ms_t;
    typedef logic [PeriodW-1:0]  period_t;
    typedef logic [LevelW-1:0]   level_t;
    typedef logic [PatternW-1:0] pattern_t;
    typedef logic [CfgIdxW-1:0]  cfg_idx_t;
    typedef logic [CfgDataW-1:0] cfg_data_t;

    // Action codes of an input item.
    localparam action_t ACT_UPDATE = 2'd0;
    localparam action_t ACT_ERROR  = 2'd1;
    localparam action_t ACT_FLASH  = 2'd2;

    // Configuration register indexes.
    localparam cfg_idx_t REG_SILENT_MODE  = 3'd0;
    localparam cfg_idx_t REG_FLASH_MS     = 3'd1;
    localparam cfg_idx_t REG_ERROR_ON_MS  = 3'd2;
    localparam cfg_idx_t REG_ERROR_OFF_MS = 3'd3;
    localparam cfg_idx_t REG_FADE_STEP_MS = 3'd4;
    localparam cfg_idx_t REG_FADE_TOP     = 3'd5;
    localparam cfg_idx_t REG_FADE_BOTTOM  = 3'd6;

    // Configuration reset values.
    localparam period_t RST_FLASH_MS     = 16'd50;
    localparam period_t RST_ERROR_ON_MS  = 16'd900;
    localparam period_t RST_ERROR_OFF_MS = 16'd100;
    localparam period_t RST_FADE_STEP_MS = 16'd48;
    localparam level_t  RST_FADE_TOP     = 8'd48;
    localparam level_t  RST_FADE_BOTTOM  = 8'd8;

    // Pattern codes reported with each result.
    localparam pattern_t PAT_LAMP_TEST = 3'd0;
    localparam pattern_t PAT_HEARTBEAT = 3'd1;
    localparam pattern_t PAT_SILENT    = 3'd2;
    localparam pattern_t PAT_FLASH     = 3'd3;
    localparam pattern_t PAT_ERROR     = 3'd4;

    // A zero period counts as one millisecond.
    function automatic period_t at_least_one(input period_t p);
        at_least_one = (p == '0) ? period_t'(1) : p;
    endfunction

endpackage

// ===== rtl/slps_channels.sv =====
// Handshake channel interfaces of the status LED pattern sequencer.
interface slps_cmd_if
    import slps_pkg::*;
();
    logic     valid;
    logic     ready;
    action_t  action;
    time_ms_t now_ms;

    modport source (output valid, output action, output now_ms, input ready);
    modport sink   (input valid, input action, input now_ms, output ready);
endinterface

interface slps_led_if
    import slps_pkg::*;
();
    logic     valid;
    logic     ready;
    level_t   duty;
    pattern_t pattern;

    modport source (output valid, output duty, output pattern, input ready);
    modport sink   (input valid, input duty, input pattern, output ready);
endinterface

interface slps_cfg_if
    import slps_pkg::*;
();
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/status_led_pattern_sequencer.sv =====
// Top level of the status LED pattern sequencer: input stage, phase logic, result stage.
//
// Usage: every item on the cmd channel carries a millisecond timestamp and an
// action (update, error request or flash request). For every accepted item the
// block returns exactly one item on the led channel: the PWM duty now driven to
// the LED and the pattern code (lamp test, heartbeat, silent, flash, error).
// The cfg channel writes the seven configuration registers by index; it is
// always ready and should only be used while no item is in flight.
// Timing: an accepted item is held in the input register; its result is
// computed combinationally and captured in the result register once that
// register is free or being drained. Throughput is one item per cycle while
// the receiver keeps up; the phase logic resolves the whole transition chain of
// an item combinationally between the input register and the result register.
// While the receiver stalls, the result register holds its item and the input
// register can still take one more item, after which cmd.ready drops.
// Reset puts the block in the lamp-test entry state with the configuration at
// its defaults; the lamp test starts with the first item.
module status_led_pattern_sequencer
    import slps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    slps_cmd_if.sink   cmd,
    slps_led_if.source led,
    slps_cfg_if.sink   cfg
);

    // Phase codes of the sequencer.
    localparam logic [3:0] PH_LT0 = 4'd0;
    localparam logic [3:0] PH_LT1 = 4'd1;
    localparam logic [3:0] PH_HB0 = 4'd2;
    localparam logic [3:0] PH_HB1 = 4'd3;
    localparam logic [3:0] PH_SI0 = 4'd4;
    localparam logic [3:0] PH_SI1 = 4'd5;
    localparam logic [3:0] PH_FL0 = 4'd6;
    localparam logic [3:0] PH_FL1 = 4'd7;
    localparam logic [3:0] PH_FL2 = 4'd8;
    localparam logic [3:0] PH_ER0 = 4'd9;
    localparam logic [3:0] PH_ER1 = 4'd10;
    localparam logic [3:0] PH_ER2 = 4'd11;

    localparam level_t LAMP_RUNS    = 8'd4;
    localparam level_t FLASH_RESUME = 8'd128;
    localparam level_t FULL_ON      = 8'd255;
    localparam level_t RAMP_END     = 8'd51;

    // Configuration registers.
    logic    silent_mode_reg;
    period_t flash_ms_reg;
    period_t error_on_ms_reg;
    period_t error_off_ms_reg;
    period_t fade_step_ms_reg;
    level_t  fade_top_reg;
    level_t  fade_bottom_reg;

    // Sequencer state.
    logic [3:0] phase_reg, phase_next;
    logic [3:0] queued_reg, queued_next;
    level_t     level_reg, level_next;
    logic       rising_reg, rising_next;
    time_ms_t   mark_reg, mark_next;
    level_t     duty_reg, duty_next;

    // Input register and result register.
    logic     s1_valid_reg;
    action_t  s1_action_reg;
    time_ms_t s1_now_reg;
    logic     out_valid_reg;
    level_t   out_duty_reg;
    pattern_t out_pattern_reg;

    logic     s1_fire;
    time_ms_t delta;
    logic     ge_flash, ge_err_on, ge_err_off, ge_fade;
    level_t   ramp_drop;
    level_t   step_level;
    logic     step_rising;
    logic     step_silent;
    logic [3:0] phase_start;
    logic       run_chain;
    pattern_t   pattern_next;

    // The input item moves on whenever the result register is free or drained.
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || led.ready);
    assign cmd.ready = !s1_valid_reg || s1_fire;
    assign cfg.ready = 1'b1;

    assign led.valid   = out_valid_reg;
    assign led.duty    = out_duty_reg;
    assign led.pattern = out_pattern_reg;

    // Every timed wait compares the same elapsed time since the last mark.
    // Once a transition re-marks, later waits in the chain see zero elapsed
    // time and cannot fire, so each chain below resolves without iteration.
    assign delta      = s1_now_reg - mark_reg;
    assign ge_flash   = delta >= {16'd0, at_least_one(flash_ms_reg)};
    assign ge_err_on  = delta >= {16'd0, at_least_one(error_on_ms_reg)};
    assign ge_err_off = delta >= {16'd0, at_least_one(error_off_ms_reg)};
    assign ge_fade    = delta >= {16'd0, at_least_one(fade_step_ms_reg)};

    // Lamp-test ramp: 5 per ms; only used while delta is below RAMP_END.
    assign ramp_drop = {delta[5:0], 2'b00} + {2'b00, delta[5:0]};

    // One heartbeat step: turn at the top, turn up or go silent at the bottom.
    always_comb
    begin
        step_rising = rising_reg;
        step_silent = 1'b0;
        if (level_reg >= fade_top_reg)
        begin
            step_rising = 1'b0;
        end
        else if (level_reg <= fade_bottom_reg)
        begin
            step_rising = 1'b1;
            step_silent = silent_mode_reg;
        end
        step_level = step_rising ? level_reg + 8'd1 : level_reg - 8'd1;
    end

    // Request handling picks the phase the chain starts from.
    always_comb
    begin
        phase_start = phase_reg;
        run_chain   = 1'b1;
        queued_next = queued_reg;
        unique case (s1_action_reg)
            ACT_ERROR:
            begin
                if (phase_reg == PH_ER0 || phase_reg == PH_ER1 || phase_reg == PH_ER2)
                begin
                    run_chain = 1'b0;
                end
                else
                begin
                    phase_start = PH_ER0;
                end
            end
            ACT_FLASH:
            begin
                if (phase_reg == PH_FL0 || phase_reg == PH_FL1 || phase_reg == PH_FL2)
                begin
                    run_chain   = 1'b0;
                    queued_next = PH_FL2;
                end
                else
                begin
                    phase_start = PH_FL0;
                end
            end
            default:
            begin
                phase_start = phase_reg;
            end
        endcase

        phase_next  = phase_start;
        level_next  = level_reg;
        rising_next = rising_reg;
        mark_next   = mark_reg;
        duty_next   = duty_reg;

        if (run_chain)
        begin
            unique case (phase_start)
                PH_LT0:
                begin
                    level_next = '0;
                    duty_next  = FULL_ON;
                    mark_next  = s1_now_reg;
                    phase_next = PH_LT1;
                end
                PH_LT1:
                begin
                    if (ge_flash)
                    begin
                        level_next = level_reg + 8'd1;
                        if (level_next <= LAMP_RUNS)
                        begin
                            duty_next = FULL_ON;
                            mark_next = s1_now_reg;
                        end
                        else if (silent_mode_reg)
                        begin
                            duty_next  = '0;
                            phase_next = PH_SI1;
                        end
                        else
                        begin
                            mark_next  = s1_now_reg;
                            phase_next = PH_HB1;
                        end
                    end
                    else
                    begin
                        duty_next = (delta >= {24'd0, RAMP_END}) ? '0 : FULL_ON - ramp_drop;
                    end
                end
                PH_HB0:
                begin
                    mark_next  = s1_now_reg;
                    phase_next = PH_HB1;
                end
                PH_HB1:
                begin
                    if (ge_fade)
                    begin
                        rising_next = step_rising;
                        level_next  = step_level;
                        mark_next   = s1_now_reg;
                        if (step_silent)
                        begin
                            duty_next  = '0;
                            phase_next = PH_SI1;
                        end
                        else
                        begin
                            duty_next = step_level;
                        end
                    end
                end
                PH_SI0:
                begin
                    duty_next = '0;
                    if (silent_mode_reg)
                    begin
                        phase_next = PH_SI1;
                    end
                    else
                    begin
                        mark_next  = s1_now_reg;
                        phase_next = PH_HB1;
                    end
                end
                PH_SI1:
                begin
                    if (!silent_mode_reg)
                    begin
                        mark_next  = s1_now_reg;
                        phase_next = PH_HB1;
                    end
                end
                PH_FL0:
                begin
                    duty_next  = FULL_ON;
                    mark_next  = s1_now_reg;
                    phase_next = PH_FL1;
                end
                PH_FL1:
                begin
                    if (ge_flash)
                    begin
                        mark_next   = s1_now_reg;
                        queued_next = silent_mode_reg ? PH_SI0 : PH_HB0;
                        if (queued_reg == PH_FL2)
                        begin
                            duty_next  = '0;
                            phase_next = PH_FL2;
                        end
                        else
                        begin
                            level_next  = FLASH_RESUME;
                            rising_next = 1'b0;
                            duty_next   = FLASH_RESUME;
                            if (queued_reg == PH_HB0)
                            begin
                                phase_next = PH_HB1;
                            end
                            else if (queued_reg == PH_SI0)
                            begin
                                duty_next  = '0;
                                phase_next = silent_mode_reg ? PH_SI1 : PH_HB1;
                            end
                            else
                            begin
                                phase_next = queued_reg;
                            end
                        end
                    end
                end
                PH_FL2:
                begin
                    if (ge_flash)
                    begin
                        duty_next  = FULL_ON;
                        mark_next  = s1_now_reg;
                        phase_next = PH_FL1;
                    end
                end
                PH_ER0:
                begin
                    duty_next  = FULL_ON;
                    mark_next  = s1_now_reg;
                    phase_next = PH_ER1;
                end
                PH_ER1:
                begin
                    if (ge_err_on)
                    begin
                        duty_next  = '0;
                        mark_next  = s1_now_reg;
                        phase_next = PH_ER2;
                    end
                end
                PH_ER2:
                begin
                    if (ge_err_off)
                    begin
                        duty_next  = FULL_ON;
                        mark_next  = s1_now_reg;
                        phase_next = PH_ER1;
                    end
                end
                default:
                begin
                    phase_next = phase_start;
                end
            endcase
        end
    end

    // Pattern code of the phase left behind by this item.
    always_comb
    begin
        unique case (phase_next)
            PH_HB0, PH_HB1:         pattern_next = PAT_HEARTBEAT;
            PH_SI0, PH_SI1:         pattern_next = PAT_SILENT;
            PH_FL0, PH_FL1, PH_FL2: pattern_next = PAT_FLASH;
            PH_ER0, PH_ER1, PH_ER2: pattern_next = PAT_ERROR;
            default:                pattern_next = PAT_LAMP_TEST;
        endcase
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silent_mode_reg  <= 1'b0;
            flash_ms_reg     <= RST_FLASH_MS;
            error_on_ms_reg  <= RST_ERROR_ON_MS;
            error_off_ms_reg <= RST_ERROR_OFF_MS;
            fade_step_ms_reg <= RST_FADE_STEP_MS;
            fade_top_reg     <= RST_FADE_TOP;
            fade_bottom_reg  <= RST_FADE_BOTTOM;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_SILENT_MODE:  silent_mode_reg  <= cfg.data[0];
                REG_FLASH_MS:     flash_ms_reg     <= cfg.data;
                REG_ERROR_ON_MS:  error_on_ms_reg  <= cfg.data;
                REG_ERROR_OFF_MS: error_off_ms_reg <= cfg.data;
                REG_FADE_STEP_MS: fade_step_ms_reg <= cfg.data;
                REG_FADE_TOP:     fade_top_reg     <= cfg.data[LevelW-1:0];
                REG_FADE_BOTTOM:  fade_bottom_reg  <= cfg.data[LevelW-1:0];
                default:          silent_mode_reg  <= silent_mode_reg;
            endcase
        end
    end

    // Sequencer state and handshake control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LT0;
            queued_reg    <= PH_HB0;
            level_reg     <= '0;
            rising_reg    <= 1'b1;
            mark_reg      <= '0;
            duty_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                phase_reg  <= phase_next;
                queued_reg <= queued_next;
                level_reg  <= level_next;
                rising_reg <= rising_next;
                mark_reg   <= mark_next;
                duty_reg   <= duty_next;
            end
            if (cmd.valid && cmd.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (led.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_action_reg <= cmd.action;
            s1_now_reg    <= cmd.now_ms;
        end
        if (s1_fire)
        begin
            out_duty_reg    <= duty_next;
            out_pattern_reg <= pattern_next;
        end
    end

    // A result is offered in the cycle after the input stage hands it over.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("result register did not capture a processed item");

    // The double-flash slot only ever names an idle entry or the dark flash phase.
    a_queued_legal: assert property (@(posedge clk) disable iff (!rst_n)
        queued_reg == PH_HB0 || queued_reg == PH_SI0 || queued_reg == PH_FL2)
        else $error("queued phase holds an unexpected code");

    // The lamp test runs at most five periods.
    a_lamp_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LT1 |-> level_reg <= LAMP_RUNS)
        else $error("lamp test ran past its last period");

    // The error blink is fully lit or fully dark.
    a_error_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ER1 |-> duty_reg == FULL_ON)
        and (phase_reg == PH_ER2 |-> duty_reg == '0))
        else $error("error blink duty out of step with its phase");

    // A silent result always reports a dark LED.
    a_silent_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_pattern_reg == PAT_SILENT |-> out_duty_reg == '0)
        else $error("silent pattern reported with a lit LED");

endmodule

// ===== dv/tb_status_led_pattern_sequencer.sv =====
// Testbench for the status LED pattern sequencer: directed and random items checked against a predictor.
module tb_status_led_pattern_sequencer
    import slps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Constants of the sequencer behavior and of the run.
    // ------------------------------------------------------------------

    // Action code three has no meaning of its own; the block treats it as an update.
    localparam action_t  ACT_RESERVED = 2'd3;
    // The configuration index space has one slot with no register behind it.
    localparam cfg_idx_t REG_UNUSED   = 3'd7;

    localparam level_t DUTY_FULL    = 8'd255;
    localparam level_t DUTY_OFF     = 8'd0;
    localparam level_t RESUME_LEVEL = 8'd128;   // heartbeat restarts here after a flash
    localparam int     LAMP_STEP    = 5;        // lamp test ramp, duty units per ms
    localparam int     LAMP_DARK_MS = 51;       // from here on the ramp would reach zero or go negative
    localparam int     LAMP_REPEATS = 4;        // level counts ramps; five in all
    localparam int     CHAIN_LIMIT  = 8;        // transitions resolved in one item at most

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 4;
    localparam int TAIL_CYCLES  = 4;            // slack after the last result has come back
    localparam int TIMEOUT_NS   = 5_000_000;

    // Phases of the predictor; they follow the block's phase chain one for one.
    typedef enum logic [3:0] {
        PH_LAMP_ENTRY,
        PH_LAMP_RAMP,
        PH_BEAT_ENTRY,
        PH_BEAT_STEP,
        PH_QUIET_ENTRY,
        PH_QUIET_HOLD,
        PH_FLASH_ENTRY,
        PH_FLASH_ON,
        PH_FLASH_OFF,
        PH_ERR_ENTRY,
        PH_ERR_ON,
        PH_ERR_OFF
    } led_phase_t;

    // How the LED side takes result items.
    typedef enum int {
        RX_STEADY,      // always ready
        RX_COIN,        // ready about 70 percent of cycles
        RX_COMB,        // fixed on/off comb
        RX_SLUGGISH     // ready about 25 percent of cycles
    } rx_mode_t;

    typedef struct packed {
        level_t   duty;
        pattern_t pattern;
    } led_item_t;

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block itself.
    // ------------------------------------------------------------------

    logic clk = 1'b0;
    logic rst_n;

    slps_cmd_if cmd_ch ();
    slps_led_if led_ch ();
    slps_cfg_if cfg_ch ();

    status_led_pattern_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .led   (led_ch),
        .cfg   (cfg_ch)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the sequencer's state and registers.
    // ------------------------------------------------------------------

    led_phase_t sq_phase;
    led_phase_t sq_queued;      // where a running flash goes when its pulse ends
    level_t     sq_level;
    logic       sq_rising;
    time_ms_t   sq_mark;        // time stamp the current timed wait started at
    level_t     sq_duty;

    logic       cf_silent;
    period_t    cf_flash_ms;
    period_t    cf_err_on_ms;
    period_t    cf_err_off_ms;
    period_t    cf_step_ms;
    level_t     cf_top;
    level_t     cf_bottom;

    // Results owed by the block, oldest first.
    led_item_t  led_due[$];
    int         fail_count = 0;

    // Stimulus controls shared between the tests and the driving processes.
    time_ms_t    clock_ms;
    int unsigned dt_span;
    logic        tx_bursty;
    int unsigned tx_burst_left = 0;
    rx_mode_t    rx_mode = RX_STEADY;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_tick = 0;

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------

    function automatic void reset_predictor();
        cf_silent     = 1'b0;
        cf_flash_ms   = RST_FLASH_MS;
        cf_err_on_ms  = RST_ERROR_ON_MS;
        cf_err_off_ms = RST_ERROR_OFF_MS;
        cf_step_ms    = RST_FADE_STEP_MS;
        cf_top        = RST_FADE_TOP;
        cf_bottom     = RST_FADE_BOTTOM;
        sq_phase      = PH_LAMP_ENTRY;
        sq_queued     = PH_BEAT_ENTRY;
        sq_level      = '0;
        sq_rising     = 1'b1;
        sq_mark       = '0;
        sq_duty       = '0;
    endfunction

    // A period register of zero still makes every wait last one millisecond.
    function automatic time_ms_t span_of(input period_t p);
        if (p == '0)
            return time_ms_t'(1);
        return time_ms_t'(p);
    endfunction

    function automatic led_phase_t idle_entry();
        if (cf_silent)
            return PH_QUIET_ENTRY;
        return PH_BEAT_ENTRY;
    endfunction

    function automatic logic in_flash(input led_phase_t p);
        return p == PH_FLASH_ENTRY || p == PH_FLASH_ON || p == PH_FLASH_OFF;
    endfunction

    function automatic logic in_error(input led_phase_t p);
        return p == PH_ERR_ENTRY || p == PH_ERR_ON || p == PH_ERR_OFF;
    endfunction

    function automatic pattern_t pattern_for(input led_phase_t p);
        case (p)
            PH_BEAT_ENTRY, PH_BEAT_STEP:               return PAT_HEARTBEAT;
            PH_QUIET_ENTRY, PH_QUIET_HOLD:             return PAT_SILENT;
            PH_FLASH_ENTRY, PH_FLASH_ON, PH_FLASH_OFF: return PAT_FLASH;
            PH_ERR_ENTRY, PH_ERR_ON, PH_ERR_OFF:       return PAT_ERROR;
            default:                                   return PAT_LAMP_TEST;
        endcase
    endfunction

    // Resolve the transition chain for one time stamp. Every pass either moves
    // to another phase or leaves the chain; entry phases fall straight through.
    function automatic void run_led_chain(input time_ms_t now);
        led_phase_t was;
        time_ms_t   elapsed;
        for (int n = 0; n < CHAIN_LIMIT; n++)
        begin
            was     = sq_phase;
            elapsed = now - sq_mark;
            case (sq_phase)
                PH_FLASH_ENTRY:
                begin
                    sq_duty  = DUTY_FULL;
                    sq_mark  = now;
                    sq_phase = PH_FLASH_ON;
                end
                PH_FLASH_ON:
                    if (elapsed >= span_of(cf_flash_ms))
                    begin
                        // A single flash hands over to the heartbeat at mid level,
                        // a queued second flash first goes dark for one period.
                        if (sq_queued != PH_FLASH_OFF)
                        begin
                            sq_level  = RESUME_LEVEL;
                            sq_rising = 1'b0;
                            sq_duty   = sq_level;
                        end
                        else
                            sq_duty = DUTY_OFF;
                        sq_mark   = now;
                        sq_phase  = sq_queued;
                        sq_queued = idle_entry();
                    end
                PH_FLASH_OFF:
                    if (elapsed >= span_of(cf_flash_ms))
                    begin
                        sq_duty  = DUTY_FULL;
                        sq_mark  = now;
                        sq_phase = PH_FLASH_ON;
                    end
                PH_ERR_ENTRY:
                begin
                    sq_duty  = DUTY_FULL;
                    sq_mark  = now;
                    sq_phase = PH_ERR_ON;
                end
                PH_ERR_ON:
                    if (elapsed >= span_of(cf_err_on_ms))
                    begin
                        sq_duty  = DUTY_OFF;
                        sq_mark  = now;
                        sq_phase = PH_ERR_OFF;
                    end
                PH_ERR_OFF:
                    if (elapsed >= span_of(cf_err_off_ms))
                    begin
                        sq_duty  = DUTY_FULL;
                        sq_mark  = now;
                        sq_phase = PH_ERR_ON;
                    end
                PH_BEAT_ENTRY:
                begin
                    sq_mark  = now;
                    sq_phase = PH_BEAT_STEP;
                end
                PH_BEAT_STEP:
                    if (elapsed >= span_of(cf_step_ms))
                    begin
                        if (sq_level >= cf_top)
                            sq_rising = 1'b0;
                        else if (sq_level <= cf_bottom)
                        begin
                            sq_rising = 1'b1;
                            if (cf_silent)
                                sq_phase = PH_QUIET_ENTRY;
                        end
                        // The level wraps modulo 256 if the limits allow it.
                        sq_level = sq_rising ? sq_level + 8'd1 : sq_level - 8'd1;
                        sq_duty  = sq_level;
                        sq_mark  = now;
                    end
                PH_QUIET_ENTRY:
                begin
                    sq_duty  = DUTY_OFF;
                    sq_phase = PH_QUIET_HOLD;
                end
                PH_QUIET_HOLD:
                    if (!cf_silent)
                        sq_phase = PH_BEAT_ENTRY;
                PH_LAMP_ENTRY:
                begin
                    sq_level = '0;
                    sq_duty  = DUTY_FULL;
                    sq_mark  = now;
                    sq_phase = PH_LAMP_RAMP;
                end
                PH_LAMP_RAMP:
                    if (elapsed >= span_of(cf_flash_ms))
                    begin
                        sq_level = sq_level + 8'd1;
                        if (sq_level <= LAMP_REPEATS)
                        begin
                            sq_duty = DUTY_FULL;
                            sq_mark = now;
                        end
                        else
                            sq_phase = idle_entry();
                    end
                    else if (elapsed >= LAMP_DARK_MS)
                        sq_duty = DUTY_OFF;     // the ramp stops at dark
                    else
                        sq_duty = level_t'(DUTY_FULL - LAMP_STEP * elapsed);
                default:
                    ;
            endcase
            if (sq_phase == was)
                break;
        end
    endfunction

    // Apply one accepted item to the predictor and return the LED item it owes.
    function automatic led_item_t predict_led(input action_t act, input time_ms_t now);
        led_item_t res;
        case (act)
            ACT_ERROR:
                // A running error blink is latched; a new request changes nothing.
                if (!in_error(sq_phase))
                begin
                    sq_phase = PH_ERR_ENTRY;
                    run_led_chain(now);
                end
            ACT_FLASH:
                // A request during a flash only books the second pulse.
                if (in_flash(sq_phase))
                    sq_queued = PH_FLASH_OFF;
                else
                begin
                    sq_phase = PH_FLASH_ENTRY;
                    run_led_chain(now);
                end
            default:
                run_led_chain(now);
        endcase
        res.duty    = sq_duty;
        res.pattern = pattern_for(sq_phase);
        return res;
    endfunction

    function automatic void load_register(input cfg_idx_t idx, input cfg_data_t data);
        case (idx)
            REG_SILENT_MODE:  cf_silent     = data[0];
            REG_FLASH_MS:     cf_flash_ms   = data;
            REG_ERROR_ON_MS:  cf_err_on_ms  = data;
            REG_ERROR_OFF_MS: cf_err_off_ms = data;
            REG_FADE_STEP_MS: cf_step_ms    = data;
            REG_FADE_TOP:     cf_top        = data[LevelW-1:0];
            REG_FADE_BOTTOM:  cf_bottom     = data[LevelW-1:0];
            default:          ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Observation. Everything is sampled at the rising edge, before the block's
    // own registers update, so the order of processes within the edge does not
    // matter. Results are checked before the new item's expectation is queued,
    // otherwise a stray result could be matched against an item accepted at the
    // same edge.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        led_item_t want;
        if (rst_n)
        begin
            if (led_ch.valid && led_ch.ready)
            begin
                if (led_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: LED item with nothing owed: duty %0d pattern %0d",
                                 $time, led_ch.duty, led_ch.pattern);
                end
                else
                begin
                    want = led_due.pop_front();
                    if (led_ch.duty !== want.duty)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: duty mismatch: expected %0d, got %0d",
                                     $time, want.duty, led_ch.duty);
                    end
                    if (led_ch.pattern !== want.pattern)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: pattern mismatch: expected %0d, got %0d",
                                     $time, want.pattern, led_ch.pattern);
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
                led_due.push_back(predict_led(cmd_ch.action, cmd_ch.now_ms));
            if (cfg_ch.valid && cfg_ch.ready)
                load_register(cfg_ch.index, cfg_ch.data);
        end
    end

    // ------------------------------------------------------------------
    // LED side: takes result items on a pattern of its own. A hold-off request
    // from a test keeps ready low until its count, kept here, runs out, so the
    // block fills up and has to stall its input.
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_hold_req != 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            led_ch.ready <= 1'b0;
        end
        else
            case (rx_mode)
                RX_STEADY:   led_ch.ready <= 1'b1;
                RX_COIN:     led_ch.ready <= ($urandom_range(0, 99) < 70);
                RX_COMB:     led_ch.ready <= ((rx_tick % 7) < 4);
                default:     led_ch.ready <= ($urandom_range(0, 99) < 25);
            endcase
    end

    // ------------------------------------------------------------------
    // Driving tasks. All of them start and return at a falling edge. A valid
    // that carries straight on to the next item stays high; only a gap or a
    // wait for the results lowers it.
    // ------------------------------------------------------------------

    task automatic send_cmd(input action_t act, input time_ms_t stamp);
        int unsigned gap;
        if (tx_bursty && tx_burst_left == 0)
        begin
            gap           = $urandom_range(1, 7);
            tx_burst_left = $urandom_range(1, 16);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (tx_burst_left != 0)
            tx_burst_left--;
        cmd_ch.valid  <= 1'b1;
        cmd_ch.action <= act;
        cmd_ch.now_ms <= stamp;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    // Advance the millisecond clock, modulo 2^32, and send one item stamped with it.
    task automatic send_at(input action_t act, input time_ms_t dt);
        clock_ms = clock_ms + dt;
        send_cmd(act, clock_ms);
    endtask

    // Stop offering items and wait until every owed LED item has come back.
    task automatic settle_outputs();
        cmd_ch.valid <= 1'b0;
        while (led_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_one(input cfg_idx_t idx, input cfg_data_t data);
        write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    // Rewrite all seven registers once the block has gone quiet.
    task automatic set_config(input cfg_data_t silent, input cfg_data_t flash,
                              input cfg_data_t err_on, input cfg_data_t err_off,
                              input cfg_data_t step, input cfg_data_t top,
                              input cfg_data_t bottom);
        settle_outputs();
        write_reg(REG_SILENT_MODE, silent);
        write_reg(REG_FLASH_MS, flash);
        write_reg(REG_ERROR_ON_MS, err_on);
        write_reg(REG_ERROR_OFF_MS, err_off);
        write_reg(REG_FADE_STEP_MS, step);
        write_reg(REG_FADE_TOP, top);
        write_reg(REG_FADE_BOTTOM, bottom);
        cfg_ch.valid <= 1'b0;
    endtask

    // Time steps: mostly within the span of the current periods, some zero,
    // some several periods long, and a few arbitrary jumps that may even run
    // the clock backward.
    function automatic time_ms_t next_dt();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        if (pick < 85)
            return $urandom_range(1, dt_span);
        if (pick < 97)
            return $urandom_range(dt_span, 4 * dt_span);
        return $urandom();
    endfunction

    // Mostly time updates so that timed phases run their course, with flash
    // requests (single and double), error requests and the reserved action mixed in.
    task automatic random_items(input int count);
        int left;
        int pick;
        left = count;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 66)
            begin
                send_at(ACT_UPDATE, next_dt());
                left--;
            end
            else if (pick < 76)
            begin
                send_at(ACT_FLASH, next_dt());
                left--;
            end
            else if (pick < 84)
            begin
                // Second request lands inside the first pulse most of the time.
                send_at(ACT_FLASH, next_dt());
                send_at(ACT_FLASH, $urandom_range(0, dt_span / 2));
                left -= 2;
            end
            else if (pick < 92)
            begin
                send_at(ACT_ERROR, next_dt());
                left--;
            end
            else
            begin
                send_at(ACT_RESERVED, next_dt());
                left--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Lamp test right after reset. The period is stretched so the ramp runs past
    // zero and has to stop at dark; the time stamps cross the 32-bit wrap, with
    // all-ones and all-zeros among them.
    task automatic test_lamp_test();
        tx_bursty = 1'b0;
        rx_mode   = RX_STEADY;
        write_one(REG_FLASH_MS, 16'd80);
        clock_ms = 32'hFFFF_FFB0;
        send_at(ACT_UPDATE, 0);
        send_at(ACT_UPDATE, 10);
        send_at(ACT_UPDATE, 40);
        send_at(ACT_UPDATE, 1);
        send_at(ACT_UPDATE, 28);
        send_at(ACT_UPDATE, 1);
        // Each long step ends one ramp; the fifth end drops into the heartbeat.
        repeat (4) send_at(ACT_UPDATE, 100);
        settle_outputs();
    endtask

    // Heartbeat steps with the default timing, the last one just short of a period.
    task automatic test_heartbeat();
        tx_bursty = 1'b1;
        rx_mode   = RX_COIN;
        write_one(REG_FLASH_MS, RST_FLASH_MS);
        send_at(ACT_UPDATE, 48);
        send_at(ACT_UPDATE, 48);
        send_at(ACT_UPDATE, 48);
        send_at(ACT_UPDATE, 47);
        settle_outputs();
    endtask

    // Single pulse with a second request during it: dark gap, second pulse,
    // then the heartbeat picks up from mid level.
    task automatic test_double_flash();
        send_at(ACT_FLASH, 5);
        send_at(ACT_UPDATE, 20);
        send_at(ACT_FLASH, 10);
        send_at(ACT_UPDATE, 20);
        send_at(ACT_UPDATE, 50);
        send_at(ACT_UPDATE, 50);
        settle_outputs();
    endtask

    // Error blink through both halves, a repeated request that must be ignored,
    // and a flash as the only way out.
    task automatic test_error_blink();
        rx_mode = RX_COMB;
        send_at(ACT_ERROR, 3);
        send_at(ACT_UPDATE, 900);
        send_at(ACT_ERROR, 10);
        send_at(ACT_UPDATE, 90);
        send_at(ACT_FLASH, 1);
        send_at(ACT_UPDATE, 50);
        settle_outputs();
    endtask

    task automatic test_reserved_action();
        send_at(ACT_RESERVED, 7);
        settle_outputs();
    endtask

    // ------------------------------------------------------------------
    // Random tests, each under its own settings and idling.
    // ------------------------------------------------------------------

    // Short periods and a narrow fade band so every phase turns over quickly.
    task automatic test_short_periods();
        set_config(16'd0, 16'd5, 16'd7, 16'd3, 16'd2, 16'd132, 16'd124);
        dt_span   = 12;
        tx_bursty = 1'b1;
        rx_mode   = RX_COIN;
        random_items(250);
        settle_outputs();
    endtask

    // Silent mode: the heartbeat sinks to the bottom and goes dark, then comes
    // back once silent mode is cleared.
    task automatic test_silent_mode();
        set_config(16'd1, 16'd9, 16'd4, 16'd6, 16'd1, 16'd140, 16'd120);
        dt_span   = 15;
        tx_bursty = 1'b0;
        rx_mode   = RX_SLUGGISH;
        random_items(150);
        set_config(16'd0, 16'd9, 16'd4, 16'd6, 16'd1, 16'd140, 16'd120);
        tx_bursty = 1'b1;
        rx_mode   = RX_STEADY;
        random_items(100);
        settle_outputs();
    endtask

    // Register extremes: longest periods with the widest band, then shortest
    // periods with an inverted band, which makes the level wrap below zero.
    task automatic test_register_extremes();
        set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd0);
        dt_span   = 70000;
        tx_bursty = 1'b1;
        rx_mode   = RX_COMB;
        random_items(120);
        set_config(16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd255);
        dt_span   = 3;
        rx_mode   = RX_COIN;
        random_items(120);
        settle_outputs();
    endtask

    // Zero periods count as one ms. The narrow registers get junk in their
    // upper data bits, which must be dropped.
    task automatic test_zero_periods();
        set_config(16'hFFFE, 16'd0, 16'd0, 16'd0, 16'd0, 16'hA582, 16'h5A7E);
        dt_span   = 3;
        tx_bursty = 1'b1;
        rx_mode   = RX_SLUGGISH;
        random_items(100);
        set_config(16'h8001, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0184, 16'hFE7C);
        tx_bursty = 1'b0;
        rx_mode   = RX_STEADY;
        random_items(100);
        settle_outputs();
    endtask

    // Back-pressure: the LED side holds off for a long stretch while items keep
    // coming, so the block fills and stalls its input; after each round the
    // sender waits for every result before going on.
    task automatic test_backpressure();
        set_config(16'd0, RST_FLASH_MS, RST_ERROR_ON_MS, RST_ERROR_OFF_MS,
                   RST_FADE_STEP_MS, cfg_data_t'(RST_FADE_TOP),
                   cfg_data_t'(RST_FADE_BOTTOM));
        dt_span = 120;
        repeat (5)
        begin
            tx_bursty   = 1'b0;
            rx_hold_req = $urandom_range(40, 80);
            random_items(25);
            tx_bursty = 1'b1;
            rx_mode   = RX_COIN;
            random_items(20);
            settle_outputs();
        end
    endtask

    // Random settings, random idling, and a write to the index with no register.
    task automatic test_mixed_settings();
        repeat (4)
        begin
            set_config(cfg_data_t'($urandom()),
                       cfg_data_t'($urandom_range(1, 300)),
                       cfg_data_t'($urandom_range(1, 300)),
                       cfg_data_t'($urandom_range(1, 300)),
                       cfg_data_t'($urandom_range(1, 300)),
                       cfg_data_t'($urandom_range(0, 255)),
                       cfg_data_t'($urandom_range(0, 255)));
            dt_span   = $urandom_range(5, 400);
            tx_bursty = 1'($urandom_range(0, 1));
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            random_items(90);
        end
        settle_outputs();
        write_one(REG_UNUSED, cfg_data_t'($urandom()));
        random_items(30);
        settle_outputs();
    endtask

    // ------------------------------------------------------------------
    // Run.
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.action = ACT_UPDATE;
        cmd_ch.now_ms = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_SILENT_MODE;
        cfg_ch.data   = '0;
        led_ch.ready  = 1'b0;
        clock_ms      = '0;
        dt_span       = 16;
        tx_bursty     = 1'b0;
        reset_predictor();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_lamp_test();
        test_heartbeat();
        test_double_flash();
        test_error_blink();
        test_reserved_action();
        test_short_periods();
        test_silent_mode();
        test_register_extremes();
        test_zero_periods();
        test_backpressure();
        test_mixed_settings();

        settle_outputs();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (led_due.size() != 0)
        begin
            fail_count += led_due.size();
            $display("%0d LED items never arrived", led_due.size());
        end
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== status_led_pattern_sequencer.f =====
rtl/slps_pkg.sv
rtl/slps_channels.sv
rtl/status_led_pattern_sequencer.sv
dv/tb_status_led_pattern_sequencer.sv
